// ===== rtl/olist_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg
// shared sizes, operation codes and status codes of the ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/olist_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olist_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module olist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                         clk,
	input  wire                         wr_en,
	input  wire  [$clog2(DEPTH)-1:0]    wr_addr,
	input  wire  [WIDTH-1:0]            wr_data,
	input  wire                         rd_en,
	input  wire  [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [WIDTH-1:0]            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ordered_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// bounded ordered list of signed 32-bit values: append, delete, search
// ----------------------------------------------------------------------------
// One beat is taken at a time, and the block stays busy until the result is
// loaded into the output register; a finished result may wait there while the
// next beat is taken. The entries live in a single-port-read ram with a
// registered read, so every entry examined passes through an address state
// and then a compare state. Append, ignored codes, and search or delete on an
// empty list go straight from acceptance to the done state, where the result
// is loaded into the output register once it is free or being taken. Search
// and delete examine the entries in order up to the first match (all of them
// when missing); a successful delete then reads and rewrites each later entry
// one place up. On a full list the longest operations are any delete and a
// search that misses. No clearing pass runs after reset.
module ordered_list_engine (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] value
	input  wire  [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [6:2] position, [11:7] entry_count
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_SH_RD = 3'd3;
	localparam logic [2:0] S_SH_WR = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam int IW = olist_pkg::IDX_W;
	localparam int CW = olist_pkg::CNT_W;
	localparam logic [CW-1:0] CAP = CW'(olist_pkg::CAPACITY);

	logic [2:0]  state_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] idx_q;
	logic [1:0]  op_q;
	logic [olist_pkg::VALUE_W-1:0] key_q;
	logic [1:0]  res_status_q;
	logic [4:0]  res_pos_q;
	logic        m_valid_q;
	logic [15:0] m_data_q;

	logic        accept;
	logic [CW-1:0] idx_nx;
	logic        wr_en;
	logic [IW-1:0] wr_addr;
	logic [olist_pkg::VALUE_W-1:0] wr_data;
	logic        rd_en;
	logic [olist_pkg::VALUE_W-1:0] rd_data;
	logic        load_out;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign idx_nx   = CW'(idx_q + 1'b1);
	assign load_out = (state_q == S_DONE) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = len_q[IW-1:0];
		wr_data = s_tdata;
		if (accept && s_tuser == olist_pkg::OP_APPEND && len_q < CAP) begin
			wr_en = 1'b1;
		end else if (state_q == S_SH_WR) begin
			// entry at idx moves up into idx-1
			wr_en   = 1'b1;
			wr_addr = IW'(idx_q - 1'b1);
			wr_data = rd_data;
		end
		rd_en = (state_q == S_RD) || (state_q == S_SH_RD);
	end

	olist_ram #(
		.WIDTH(olist_pkg::VALUE_W),
		.DEPTH(olist_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						case (s_tuser)
							olist_pkg::OP_APPEND: begin
								if (len_q < CAP) begin
									len_q <= CW'(len_q + 1'b1);
								end
							end
							olist_pkg::OP_DELETE, olist_pkg::OP_SEARCH: begin
								if (len_q != '0) begin
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rd_data == key_q) begin
						if (op_q == olist_pkg::OP_SEARCH) begin
							state_q <= S_DONE;
						end else if (idx_nx < len_q) begin
							state_q <= S_SH_RD;
						end else begin
							len_q   <= CW'(len_q - 1'b1);
							state_q <= S_DONE;
						end
					end else if (idx_nx >= len_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					if (idx_nx < len_q) begin
						state_q <= S_SH_RD;
					end else begin
						len_q   <= CW'(len_q - 1'b1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= s_tuser;
					key_q     <= s_tdata;
					idx_q     <= '0;
					res_pos_q <= '0;
					res_status_q <= olist_pkg::ST_OK;
					case (s_tuser)
						olist_pkg::OP_APPEND: begin
							if (len_q >= CAP) begin
								res_status_q <= olist_pkg::ST_FULL;
							end
						end
						olist_pkg::OP_DELETE, olist_pkg::OP_SEARCH: begin
							if (len_q == '0) begin
								res_status_q <= olist_pkg::ST_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_CMP: begin
				if (rd_data == key_q) begin
					if (op_q == olist_pkg::OP_SEARCH) begin
						res_pos_q <= 5'(idx_nx);
					end else begin
						idx_q <= idx_nx;
					end
				end else begin
					idx_q <= idx_nx;
					if (idx_nx >= len_q) begin
						res_status_q <= olist_pkg::ST_MISSING;
					end
				end
			end
			S_SH_WR: begin
				idx_q <= idx_nx;
			end
			S_DONE: begin
				if (load_out) begin
					m_data_q <= {4'd0, 5'(len_q), res_pos_q, res_status_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CAP)
		else $error("list length beyond capacity");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == olist_pkg::OP_APPEND && len_q < CAP
		|=> len_q == CW'($past(len_q) + 1'b1))
		else $error("append did not grow the list");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == olist_pkg::ST_FULL |-> m_tdata[11:7] == 5'(CAP))
		else $error("full status with a count below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == olist_pkg::ST_EMPTY |-> m_tdata[11:7] == 5'd0)
		else $error("empty status with entries held");

	a_pos_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != olist_pkg::ST_OK |-> m_tdata[6:2] == 5'd0)
		else $error("position reported on a failed operation");
`endif

endmodule
`default_nettype wire
